// ----- rtl/core/scc_pkg.sv -----
// Shared types, constants and the compute sequence for the spectral centroid block.
package scc_pkg;

  localparam int FS_W      = 18;
  localparam int N_W       = 17;
  localparam int OUT_W     = 28;
  localparam int FRAC_BINS = 16;

  localparam logic [FS_W-1:0] FS_RESET = 18'd44100;
  localparam logic [N_W-1:0]  N_RESET  = 17'd1024;

  localparam int   CFG_IDX_W       = 1;
  localparam logic CFG_SAMPLE_RATE = 1'b0;
  localparam logic CFG_XFORM_SIZE  = 1'b1;

  typedef logic [3:0] op_t;

  localparam op_t OP_NONE    = 4'd0;
  localparam op_t OP_LD_W    = 4'd1;
  localparam op_t OP_LD_WQ   = 4'd2;
  localparam op_t OP_LD_S1   = 4'd3;
  localparam op_t OP_LD_S2   = 4'd4;
  localparam op_t OP_SHL8    = 4'd5;
  localparam op_t OP_MUL     = 4'd6;
  localparam op_t OP_DIV_E   = 4'd7;
  localparam op_t OP_DIV_N   = 4'd8;
  localparam op_t OP_SQRT    = 4'd9;
  localparam op_t OP_SAV_CQ  = 4'd10;
  localparam op_t OP_SAV_CEN = 4'd11;
  localparam op_t OP_SAV_BW  = 4'd12;
  localparam op_t OP_SAV_SPR = 4'd13;
  localparam op_t OP_PASS    = 4'd14;

  localparam int PROG_LEN = 21;
  localparam int PC_W     = 5;
  typedef logic [PC_W-1:0] pc_t;

  typedef struct packed {
    logic load;
    logic pub;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic zero;
  } stat_t;

  function automatic op_t prog_op(input pc_t pc);
    op_t op;
    case (pc)
      5'd0:    op = OP_LD_W;
      5'd1:    op = OP_MUL;
      5'd2:    op = OP_SHL8;
      5'd3:    op = OP_DIV_E;
      5'd4:    op = OP_DIV_N;
      5'd5:    op = OP_SAV_CEN;
      5'd6:    op = OP_LD_WQ;
      5'd7:    op = OP_DIV_E;
      5'd8:    op = OP_SAV_CQ;
      5'd9:    op = OP_PASS;
      5'd10:   op = OP_LD_S1;
      5'd11:   op = OP_MUL;
      5'd12:   op = OP_DIV_E;
      5'd13:   op = OP_DIV_N;
      5'd14:   op = OP_SAV_BW;
      5'd15:   op = OP_LD_S2;
      5'd16:   op = OP_DIV_E;
      5'd17:   op = OP_SQRT;
      5'd18:   op = OP_MUL;
      5'd19:   op = OP_DIV_N;
      5'd20:   op = OP_SAV_SPR;
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage

// ----- rtl/core/spectral_centroid_spread.sv -----
// Spectral centroid, bandwidth and spread of one frame of magnitude bins.
// Bins load one per cycle while in_ready is high; the wait for the result after the last bin
// is dominated by the one-bit-per-cycle divider (seven divides of 105 steps) and the single
// read port of the bin store during the moment pass.
// Throughput: one frame at a time; the next frame loads while a result waits.
// Reset: synchronous active-low; clears frame sums, control and restores default config.
module spectral_centroid_spread #(
  parameter int MAX_BINS = 1024,
  parameter int MAG_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [scc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [scc_pkg::FS_W-1:0]      cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [MAG_BITS-1:0]           in_magnitude,
  input  logic                          in_last_bin,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [scc_pkg::OUT_W-1:0]     out_centroid,
  output logic [scc_pkg::OUT_W-1:0]     out_bandwidth,
  output logic [scc_pkg::OUT_W-1:0]     out_spread,
  output logic                          out_zero_energy,
  output logic                          out_truncated
);
  import scc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  scc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_last_bin (in_last_bin),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cmd         (cmd),
    .stat        (stat)
  );

  scc_datapath #(
    .MAX_BINS (MAX_BINS),
    .MAG_BITS (MAG_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_magnitude    (in_magnitude),
    .cmd             (cmd),
    .stat            (stat),
    .out_centroid    (out_centroid),
    .out_bandwidth   (out_bandwidth),
    .out_spread      (out_spread),
    .out_zero_energy (out_zero_energy),
    .out_truncated   (out_truncated)
  );

endmodule

// ----- rtl/core/scc_ram.sv -----
// Generic single write port, single read port RAM with registered read.
module scc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/scc_ctrl.sv -----
// Controller: frame load, compute sequencing and result handoff.
module scc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_last_bin,
  output logic          out_valid,
  input  logic          out_ready,
  output scc_pkg::cmd_t cmd,
  input  scc_pkg::stat_t stat
);
  import scc_pkg::*;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_ISSUE = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0] state_r, state_nxt;
  pc_t        pc_r, pc_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    cmd.op        = OP_NONE;
    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last_bin) begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        pc_nxt = '0;
        if (stat.zero) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.op    = prog_op(pc_r);
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (!stat.busy) begin
          if (pc_r == PC_W'(PROG_LEN - 1)) begin
            state_nxt = S_FIN;
          end else begin
            pc_nxt    = pc_r + 1'b1;
            state_nxt = S_ISSUE;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.pub       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = out_valid_r;

endmodule

// ----- rtl/core/scc_datapath.sv -----
// Datapath: bin store, sums, moment pass, serial multiply, divide and root.
module scc_datapath #(
  parameter int MAX_BINS = 1024,
  parameter int MAG_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [scc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [scc_pkg::FS_W-1:0]      cfg_wdata,
  input  logic [MAG_BITS-1:0]           in_magnitude,
  input  scc_pkg::cmd_t                 cmd,
  output scc_pkg::stat_t                stat,
  output logic [scc_pkg::OUT_W-1:0]     out_centroid,
  output logic [scc_pkg::OUT_W-1:0]     out_bandwidth,
  output logic [scc_pkg::OUT_W-1:0]     out_spread,
  output logic                          out_zero_energy,
  output logic                          out_truncated
);
  import scc_pkg::*;

  localparam int IDX_W = $clog2(MAX_BINS);
  localparam int CNT_W = $clog2(MAX_BINS + 1);
  localparam int E_W   = MAG_BITS + CNT_W;
  localparam int W_W   = MAG_BITS + IDX_W + CNT_W;
  localparam int D_W   = IDX_W + FRAC_BINS;
  localparam int S1_W  = D_W + MAG_BITS + CNT_W;
  localparam int S2_W  = 2 * D_W + MAG_BITS + CNT_W;
  localparam int DV_W  = S2_W + FS_W;
  localparam int DS_W  = (E_W > N_W) ? E_W : N_W;
  localparam int R_W   = 2 * D_W;
  localparam int ST_W  = $clog2(DV_W + 1);
  localparam int KX_W  = IDX_W + MAG_BITS;
  localparam int P1_W  = D_W + MAG_BITS;

  // configuration
  logic [FS_W-1:0] fs_r, fs_nxt;
  logic [N_W-1:0]  n_r, n_nxt;
  logic [FS_W-1:0] fs_eff;
  logic [N_W-1:0]  n_eff;

  // frame sums
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [E_W-1:0]   e_r, e_nxt;
  logic [W_W-1:0]   w_r, w_nxt;
  logic             ovf_r, ovf_nxt;
  logic [KX_W-1:0]  kx;

  // bin store
  logic                ram_we;
  logic [MAG_BITS-1:0] ram_rdata;

  // work register and iterative units
  logic [DV_W-1:0] x_r, x_nxt;
  logic [DV_W-1:0] mc_r, mc_nxt;
  logic [FS_W-1:0] mp_r, mp_nxt;
  logic [DS_W-1:0] rem_r, rem_nxt;
  logic [DS_W-1:0] dvs_r, dvs_nxt;
  logic [DS_W:0]   rem_sh;
  logic [R_W-1:0]  sv_r, sv_nxt;
  logic [R_W-1:0]  sres_r, sres_nxt;
  logic [R_W-1:0]  sbit_r, sbit_nxt;
  logic [R_W-1:0]  ssum;
  logic [ST_W-1:0] stp_r, stp_nxt;
  op_t             run_r, run_nxt;

  // moment pass
  logic [CNT_W-1:0]    pk_r, pk_nxt;
  logic                iss_r, iss_nxt;
  logic                pv1_r, pv1_nxt, pv2_r, pv2_nxt, pv3_r, pv3_nxt, pv4_r, pv4_nxt;
  logic [IDX_W-1:0]    k1_r, k1_nxt;
  logic [D_W-1:0]      pos;
  logic [D_W-1:0]      d2_r, d2_nxt;
  logic [MAG_BITS-1:0] x2_r, x2_nxt, x3_r, x3_nxt;
  logic [P1_W-1:0]     p1_r, p1_nxt;
  logic [R_W-1:0]      dd_r, dd_nxt;
  logic [P1_W-1:0]     plo_r, plo_nxt, phi_r, phi_nxt;
  logic [S1_W-1:0]     s1_r, s1_nxt;
  logic [S2_W-1:0]     s2_r, s2_nxt;

  // results
  logic [D_W-1:0]   cq_r, cq_nxt;
  logic [OUT_W-1:0] cen_r, cen_nxt, bw_r, bw_nxt, spr_r, spr_nxt;
  logic [OUT_W-1:0] ocen_r, ocen_nxt, obw_r, obw_nxt, ospr_r, ospr_nxt;
  logic             ozero_r, ozero_nxt, otrunc_r, otrunc_nxt;
  logic             zero;

  function automatic logic [OUT_W-1:0] sat_out(input logic [DV_W-1:0] v);
    logic [OUT_W-1:0] r;
    if (|v[DV_W-1:OUT_W]) begin
      r = '1;
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

  assign fs_eff = (fs_r == '0) ? FS_W'(1) : fs_r;
  assign n_eff  = (n_r < N_W'(2)) ? N_W'(2) : n_r;
  assign zero   = (e_r == '0);
  assign kx     = {{MAG_BITS{1'b0}}, cnt_r[IDX_W-1:0]} * {{IDX_W{1'b0}}, in_magnitude};
  assign rem_sh = {rem_r, x_r[DV_W-1]};
  assign ssum   = sres_r + sbit_r;
  assign pos    = {k1_r, {FRAC_BINS{1'b0}}};

  scc_ram #(
    .WIDTH (MAG_BITS),
    .DEPTH (MAX_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (in_magnitude),
    .raddr (pk_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    fs_nxt     = fs_r;
    n_nxt      = n_r;
    cnt_nxt    = cnt_r;
    e_nxt      = e_r;
    w_nxt      = w_r;
    ovf_nxt    = ovf_r;
    ram_we     = 1'b0;
    x_nxt      = x_r;
    mc_nxt     = mc_r;
    mp_nxt     = mp_r;
    rem_nxt    = rem_r;
    dvs_nxt    = dvs_r;
    sv_nxt     = sv_r;
    sres_nxt   = sres_r;
    sbit_nxt   = sbit_r;
    stp_nxt    = stp_r;
    run_nxt    = run_r;
    pk_nxt     = pk_r;
    iss_nxt    = iss_r;
    pv1_nxt    = 1'b0;
    k1_nxt     = k1_r;
    pv2_nxt    = pv1_r;
    pv3_nxt    = pv2_r;
    pv4_nxt    = pv3_r;
    d2_nxt     = d2_r;
    x2_nxt     = x2_r;
    x3_nxt     = x2_r;
    p1_nxt     = P1_W'(d2_r) * P1_W'(x2_r);
    dd_nxt     = R_W'(d2_r) * R_W'(d2_r);
    plo_nxt    = P1_W'(dd_r[D_W-1:0]) * P1_W'(x3_r);
    phi_nxt    = P1_W'(dd_r[R_W-1:D_W]) * P1_W'(x3_r);
    s1_nxt     = s1_r;
    s2_nxt     = s2_r;
    cq_nxt     = cq_r;
    cen_nxt    = cen_r;
    bw_nxt     = bw_r;
    spr_nxt    = spr_r;
    ocen_nxt   = ocen_r;
    obw_nxt    = obw_r;
    ospr_nxt   = ospr_r;
    ozero_nxt  = ozero_r;
    otrunc_nxt = otrunc_r;

    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SAMPLE_RATE: fs_nxt = cfg_wdata;
        CFG_XFORM_SIZE:  n_nxt  = cfg_wdata[N_W-1:0];
        default:         fs_nxt = fs_r;
      endcase
    end

    // accept a bin, drop it past capacity
    if (cmd.load) begin
      if (cnt_r < CNT_W'(MAX_BINS)) begin
        ram_we  = 1'b1;
        e_nxt   = e_r + E_W'(in_magnitude);
        w_nxt   = w_r + W_W'(kx);
        cnt_nxt = cnt_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end

    // hand the results to the output and clear the frame
    if (cmd.pub) begin
      ocen_nxt   = zero ? '0 : cen_r;
      obw_nxt    = zero ? '0 : bw_r;
      ospr_nxt   = zero ? '0 : spr_r;
      ozero_nxt  = zero;
      otrunc_nxt = ovf_r;
      cnt_nxt    = '0;
      e_nxt      = '0;
      w_nxt      = '0;
      ovf_nxt    = 1'b0;
    end

    case (cmd.op)
      OP_LD_W:    x_nxt = DV_W'(w_r);
      OP_LD_WQ:   x_nxt = DV_W'({w_r, {FRAC_BINS{1'b0}}});
      OP_LD_S1:   x_nxt = DV_W'(s1_r);
      OP_LD_S2:   x_nxt = DV_W'(s2_r);
      OP_SHL8:    x_nxt = {x_r[DV_W-9:0], 8'd0};
      OP_SAV_CQ:  cq_nxt = x_r[D_W-1:0];
      OP_SAV_CEN: cen_nxt = sat_out(x_r);
      OP_SAV_BW:  bw_nxt = sat_out({8'd0, x_r[DV_W-1:8]});
      OP_SAV_SPR: spr_nxt = sat_out({8'd0, x_r[DV_W-1:8]});
      OP_MUL: begin
        mc_nxt  = x_r;
        x_nxt   = '0;
        mp_nxt  = fs_eff;
        stp_nxt = ST_W'(FS_W);
        run_nxt = OP_MUL;
      end
      OP_DIV_E, OP_DIV_N: begin
        rem_nxt = '0;
        dvs_nxt = (cmd.op == OP_DIV_E) ? DS_W'(e_r) : DS_W'(n_eff);
        stp_nxt = ST_W'(DV_W);
        run_nxt = OP_DIV_E;
      end
      OP_SQRT: begin
        sv_nxt   = x_r[R_W-1:0];
        sres_nxt = '0;
        sbit_nxt = R_W'(1) << (R_W - 2);
        stp_nxt  = ST_W'(D_W);
        run_nxt  = OP_SQRT;
      end
      OP_PASS: begin
        pk_nxt  = '0;
        iss_nxt = 1'b1;
        s1_nxt  = '0;
        s2_nxt  = '0;
      end
      default: x_nxt = x_r;
    endcase

    // one step of the running iterative unit
    if (stp_r != '0) begin
      stp_nxt = stp_r - 1'b1;
      case (run_r)
        OP_MUL: begin
          if (mp_r[0]) begin
            x_nxt = x_r + mc_r;
          end
          mc_nxt = {mc_r[DV_W-2:0], 1'b0};
          mp_nxt = {1'b0, mp_r[FS_W-1:1]};
        end
        OP_DIV_E: begin
          if (rem_sh >= {1'b0, dvs_r}) begin
            rem_nxt = DS_W'(rem_sh - {1'b0, dvs_r});
            x_nxt   = {x_r[DV_W-2:0], 1'b1};
          end else begin
            rem_nxt = rem_sh[DS_W-1:0];
            x_nxt   = {x_r[DV_W-2:0], 1'b0};
          end
        end
        OP_SQRT: begin
          if (sv_r >= ssum) begin
            sv_nxt   = sv_r - ssum;
            sres_nxt = {1'b0, sres_r[R_W-1:1]} + sbit_r;
          end else begin
            sres_nxt = {1'b0, sres_r[R_W-1:1]};
          end
          sbit_nxt = {2'b00, sbit_r[R_W-1:2]};
          x_nxt    = DV_W'(sres_nxt);
        end
        default: stp_nxt = '0;
      endcase
    end

    // moment pass: read, deviation, products, accumulate
    if (iss_r) begin
      pv1_nxt = 1'b1;
      k1_nxt  = pk_r[IDX_W-1:0];
      pk_nxt  = pk_r + 1'b1;
      if (pk_r + 1'b1 == cnt_r) begin
        iss_nxt = 1'b0;
      end
    end
    if (pv1_r) begin
      x2_nxt = ram_rdata;
      d2_nxt = (pos >= cq_r) ? (pos - cq_r) : (cq_r - pos);
    end
    if (pv3_r) begin
      s1_nxt = s1_r + S1_W'(p1_r);
    end
    if (pv4_r) begin
      s2_nxt = s2_r + S2_W'(plo_r) + (S2_W'(phi_r) << D_W);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r  <= FS_RESET;
      n_r   <= N_RESET;
      cnt_r <= '0;
      e_r   <= '0;
      w_r   <= '0;
      ovf_r <= 1'b0;
      stp_r <= '0;
      run_r <= OP_NONE;
      iss_r <= 1'b0;
      pv1_r <= 1'b0;
      pv2_r <= 1'b0;
      pv3_r <= 1'b0;
      pv4_r <= 1'b0;
    end else begin
      fs_r  <= fs_nxt;
      n_r   <= n_nxt;
      cnt_r <= cnt_nxt;
      e_r   <= e_nxt;
      w_r   <= w_nxt;
      ovf_r <= ovf_nxt;
      stp_r <= stp_nxt;
      run_r <= run_nxt;
      iss_r <= iss_nxt;
      pv1_r <= pv1_nxt;
      pv2_r <= pv2_nxt;
      pv3_r <= pv3_nxt;
      pv4_r <= pv4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r      <= x_nxt;
    mc_r     <= mc_nxt;
    mp_r     <= mp_nxt;
    rem_r    <= rem_nxt;
    dvs_r    <= dvs_nxt;
    sv_r     <= sv_nxt;
    sres_r   <= sres_nxt;
    sbit_r   <= sbit_nxt;
    pk_r     <= pk_nxt;
    k1_r     <= k1_nxt;
    d2_r     <= d2_nxt;
    x2_r     <= x2_nxt;
    x3_r     <= x3_nxt;
    p1_r     <= p1_nxt;
    dd_r     <= dd_nxt;
    plo_r    <= plo_nxt;
    phi_r    <= phi_nxt;
    s1_r     <= s1_nxt;
    s2_r     <= s2_nxt;
    cq_r     <= cq_nxt;
    cen_r    <= cen_nxt;
    bw_r     <= bw_nxt;
    spr_r    <= spr_nxt;
    ocen_r   <= ocen_nxt;
    obw_r    <= obw_nxt;
    ospr_r   <= ospr_nxt;
    ozero_r  <= ozero_nxt;
    otrunc_r <= otrunc_nxt;
  end

  assign stat.busy = (stp_r != '0) | iss_r | pv1_r | pv2_r | pv3_r | pv4_r;
  assign stat.zero = zero;

  assign out_centroid    = ocen_r;
  assign out_bandwidth   = obw_r;
  assign out_spread      = ospr_r;
  assign out_zero_energy = ozero_r;
  assign out_truncated   = otrunc_r;

endmodule

// ----- sim/spectral_centroid_spread_tb.sv -----
// Self-checking testbench for spectral_centroid_spread: directed and random frames, six
// configuration settings, random idling on both channels and a long result hold-off.
`timescale 1ns / 1ps

module spectral_centroid_spread_tb;
  import scc_pkg::*;

  localparam int          MAX_BINS   = 1024;
  localparam int          MAG_BITS   = 24;
  localparam int          CYCLE_CAP  = 1000000;
  localparam int          HOLD_LEN   = 4000;
  localparam logic [63:0] OUT_CEIL   = 64'd268435455;
  localparam logic [23:0] MAG_FULL   = 24'hFFFFFF;

  typedef struct packed {
    logic [OUT_W-1:0] centroid;
    logic [OUT_W-1:0] bandwidth;
    logic [OUT_W-1:0] spread;
    logic             zero_energy;
    logic             truncated;
  } moments_t;

  typedef struct packed {
    logic [MAG_BITS-1:0] magnitude;
    logic                last_bin;
    logic                typed;
    moments_t            moments;
  } bin_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SAMPLE_RATE;
  logic [FS_W-1:0]       cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [MAG_BITS-1:0]   in_magnitude = '0;
  logic                  in_last_bin = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [OUT_W-1:0]      out_centroid;
  logic [OUT_W-1:0]      out_bandwidth;
  logic [OUT_W-1:0]      out_spread;
  logic                  out_zero_energy;
  logic                  out_truncated;

  // predictor state
  logic [MAG_BITS-1:0]   bin_mem [MAX_BINS];
  int                    bins_held;
  logic [63:0]           energy_sum;
  logic [63:0]           weighted_sum;
  logic                  frame_cut;
  logic [FS_W-1:0]       rate_reg;
  logic [N_W-1:0]        size_reg;

  moments_t              moments_q[$];
  int                    fault_cnt;
  int                    frames_seen;
  int                    cut_frames;
  int                    dark_frames;
  int                    bins_sent;
  int                    send_idle_pct;
  int                    stall_pct;
  int                    hold_req;
  int                    hold_seen;
  int                    hold_left;
  longint                cycle_cnt;

  spectral_centroid_spread #(
    .MAX_BINS(MAX_BINS),
    .MAG_BITS(MAG_BITS)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_magnitude    (in_magnitude),
    .in_last_bin     (in_last_bin),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_centroid    (out_centroid),
    .out_bandwidth   (out_bandwidth),
    .out_spread      (out_spread),
    .out_zero_energy (out_zero_energy),
    .out_truncated   (out_truncated)
  );

  initial begin
    forever begin
      #10 clk = ~clk;
    end
  end

  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function automatic logic [OUT_W-1:0] clamp_out(input logic [63:0] v);
    return (v > OUT_CEIL) ? OUT_CEIL[OUT_W-1:0] : v[OUT_W-1:0];
  endfunction

  // advance the frame by one bin; returns 1 with the moments on a closing bin
  function automatic bit fold_bin(input logic [MAG_BITS-1:0] mag, input logic last,
                                  output moments_t m);
    logic [63:0]  fs;
    logic [63:0]  n;
    logic [63:0]  cq;
    logic [63:0]  pos;
    logic [63:0]  d;
    logic [63:0]  lo;
    logic [127:0] acc;
    logic [127:0] s1;
    logic [127:0] s2;
    logic [63:0]  cen;
    logic [63:0]  bw;
    logic [63:0]  spr;
    m = '0;
    if (bins_held < MAX_BINS) begin
      bin_mem[bins_held] = mag;
      energy_sum = energy_sum + mag;
      weighted_sum = weighted_sum + 64'(bins_held) * mag;
      bins_held++;
    end else begin
      frame_cut = 1'b1;
    end
    if (!last) return 0;
    fs = (rate_reg == 0) ? 64'd1 : 64'(rate_reg);
    n = (size_reg < 2) ? 64'd2 : 64'(size_reg);
    cen = 0;
    bw = 0;
    spr = 0;
    if (energy_sum != 0) begin
      acc = 128'(weighted_sum) * 128'(fs << 8);
      acc = acc / energy_sum;
      lo = acc[63:0];
      cen = lo / n;
      acc = 128'(weighted_sum) << FRAC_BINS;
      acc = acc / energy_sum;
      cq = acc[63:0];
      s1 = 0;
      s2 = 0;
      for (int k = 0; k < bins_held; k++) begin
        pos = 64'(k) << FRAC_BINS;
        d = (pos >= cq) ? pos - cq : cq - pos;
        s1 = s1 + 128'(d) * bin_mem[k];
        lo = d * d;
        s2 = s2 + 128'(lo) * bin_mem[k];
      end
      acc = s1 * 128'(fs);
      acc = acc / energy_sum;
      lo = acc[63:0];
      bw = (lo / n) >> 8;
      acc = s2 / energy_sum;
      lo = floor_root(acc[63:0]) * fs;
      spr = (lo / n) >> 8;
    end
    m.centroid = clamp_out(cen);
    m.bandwidth = clamp_out(bw);
    m.spread = clamp_out(spr);
    m.zero_energy = (energy_sum == 0);
    m.truncated = frame_cut;
    bins_held = 0;
    energy_sum = 0;
    weighted_sum = 0;
    frame_cut = 1'b0;
    return 1;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FS_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == CFG_SAMPLE_RATE) rate_reg = val;
    else size_reg = val[N_W-1:0];
  endtask

  task automatic set_rates(input logic [FS_W-1:0] rate, input logic [N_W:0] size);
    write_reg(CFG_SAMPLE_RATE, rate);
    write_reg(CFG_XFORM_SIZE, FS_W'(size[N_W-1:0]));
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_bin(input logic [MAG_BITS-1:0] mag, input logic last,
                          input bit typed, input moments_t typed_m);
    moments_t m;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_magnitude <= mag;
    in_last_bin <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bins_sent++;
    if (fold_bin(mag, last, m)) moments_q.push_back(typed ? typed_m : m);
  endtask

  task automatic send_frame(input int len, input bit all_zero);
    logic [MAG_BITS-1:0] mag;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(9))
        0:       mag = '0;
        1:       mag = MAG_FULL;
        2:       mag = MAG_BITS'($urandom_range(255));
        default: mag = MAG_BITS'($urandom);
      endcase
      if (all_zero) mag = '0;
      send_bin(mag, i == len - 1, 1'b0, '0);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (moments_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t ERROR %s expected %0d got %0d", $time, name, exp_v, act_v);
      fault_cnt++;
    end
  endtask

  // result side: check, then choose ready for the next cycle
  initial begin
    moments_t m;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (moments_q.size() == 0) begin
          $display("%0t ERROR unexpected result expected none got centroid %0d",
                   $time, out_centroid);
          fault_cnt++;
        end else begin
          m = moments_q.pop_front();
          check_field("centroid", m.centroid, out_centroid);
          check_field("bandwidth", m.bandwidth, out_bandwidth);
          check_field("spread", m.spread, out_spread);
          check_field("zero_energy", m.zero_energy, out_zero_energy);
          check_field("truncated", m.truncated, out_truncated);
          frames_seen++;
          if (m.truncated) cut_frames++;
          if (m.zero_energy) dark_frames++;
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt > CYCLE_CAP) begin
        $display("timeout after %0d cycles", cycle_cnt);
        $display("spectral_centroid_spread verification failed");
        $finish;
      end
    end
  end

  initial begin
    bin_row_t         rows[$];
    moments_t         z;
    moments_t         tone;
    logic [FS_W-1:0]  rate_tab[6];
    logic [N_W:0]     size_tab[6];
    int               send_tab[6];
    int               stall_tab[6];
    int               target;
    int               len;

    fault_cnt = 0;
    frames_seen = 0;
    cut_frames = 0;
    dark_frames = 0;
    bins_sent = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    bins_held = 0;
    energy_sum = 0;
    weighted_sum = 0;
    frame_cut = 1'b0;
    rate_reg = FS_RESET;
    size_reg = N_RESET;

    z = '0;
    tone = '0;
    tone.centroid = 28'd11025;
    rows.push_back('{'0, 1'b1, 1'b1, '{28'd0, 28'd0, 28'd0, 1'b1, 1'b0}});
    rows.push_back('{MAG_FULL, 1'b1, 1'b1, z});
    rows.push_back('{'0, 1'b0, 1'b0, z});
    rows.push_back('{24'd5, 1'b1, 1'b1, tone});
    rows.push_back('{MAG_FULL, 1'b0, 1'b0, z});
    rows.push_back('{'0, 1'b0, 1'b0, z});
    rows.push_back('{MAG_FULL, 1'b0, 1'b0, z});
    rows.push_back('{24'd1, 1'b0, 1'b0, z});
    rows.push_back('{24'h800000, 1'b1, 1'b0, z});
    rows.push_back('{'0, 1'b0, 1'b0, z});
    rows.push_back('{'0, 1'b0, 1'b0, z});
    rows.push_back('{'0, 1'b1, 1'b1, '{28'd0, 28'd0, 28'd0, 1'b1, 1'b0}});
    rows.push_back('{24'hAAAAAA, 1'b0, 1'b0, z});
    rows.push_back('{24'h555555, 1'b0, 1'b0, z});
    rows.push_back('{24'h000001, 1'b0, 1'b0, z});
    rows.push_back('{MAG_FULL, 1'b1, 1'b0, z});

    rate_tab = '{18'd44100, 18'd192000, 18'd1, 18'd0, 18'd48000, 18'd0};
    size_tab = '{18'd1024, 18'd2, 18'd65536, 18'd1, 18'd512, 18'd0};
    send_tab = '{0, 64, 0, 25, 0, 0};
    stall_tab = '{0, 0, 64, 25, 0, 0};
    rate_tab[5] = FS_W'($urandom);
    size_tab[5] = 18'($urandom_range(131071));
    send_tab[5] = $urandom_range(1) ? 64 : 25;
    stall_tab[5] = send_tab[5];

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_bin(rows[i].magnitude, rows[i].last_bin, rows[i].typed,
                               rows[i].moments);
    drain();

    for (int p = 0; p < 6; p++) begin
      set_rates(rate_tab[p], size_tab[p]);
      send_idle_pct = send_tab[p];
      stall_pct = stall_tab[p];
      if (p == 0) hold_req++;
      target = bins_sent + 65;
      while (bins_sent < target) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
        send_frame(len, $urandom_range(11) == 0);
      end
      drain();
    end

    repeat (1100) @(posedge clk);
    $display("covered %0d bins in %0d frames over six rate/size settings", bins_sent,
             frames_seen);
    $display("frames cut at capacity: %0d, frames with no energy: %0d", cut_frames,
             dark_frames);
    if (fault_cnt == 0 && moments_q.size() == 0) begin
      $display("spectral_centroid_spread verification clean");
    end else begin
      $display("%0d mismatches, %0d results never seen", fault_cnt, moments_q.size());
      $display("spectral_centroid_spread verification failed");
    end
    $finish;
  end

endmodule
